// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true at a clock edge requires the consequent at the same edge.
`define UPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent true at a clock edge requires the consequent at the next edge.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define UPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/upd_pkg.sv -----
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] HEX_ALPHA  = 4'd10;

    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } upd_phase_t;

    // One decoded item: up to three output bytes, sent in order.
    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
        logic                             string_end;
    } upd_cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h61 + {4'h0, HEX_ALPHA};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h41 + {4'h0, HEX_ALPHA};
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/upd_front.sv -----
`default_nettype none

module upd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_string,
    input  wire logic             queue_full,
    output logic                  in_ready,
    output logic                  cmd_push,
    output upd_pkg::upd_cmd_t     cmd,
    output logic                  escape_pending
);

    upd_pkg::upd_phase_t phase_reg, phase_next;
    logic [7:0]          first_reg, first_next;

    logic                        accept;
    logic                        hex_in;
    logic                        plain_open;
    logic                        plain_n;
    logic [7:0]                  plain_byte;
    logic [upd_pkg::CNT_W-1:0]   count;
    logic [upd_pkg::MAX_RESULTS-1:0][7:0] bytes;

    assign in_ready       = !queue_full;
    assign accept         = in_valid && !queue_full;
    assign hex_in         = upd_pkg::is_hex(in_byte);
    assign escape_pending = (phase_reg == upd_pkg::PH_PCT) || (phase_reg == upd_pkg::PH_DIGIT);

    // A byte decoded with no escape pending; a '%' not at the end opens an escape.
    assign plain_open = (in_byte == upd_pkg::CH_PERCENT) && !end_of_string;
    assign plain_n    = !plain_open;
    assign plain_byte = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;

    always_comb
    begin
        count      = '0;
        bytes      = '0;
        phase_next = plain_open ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        first_next = first_reg;
        unique case (phase_reg)
            upd_pkg::PH_PCT:
            begin
                if (hex_in)
                begin
                    if (end_of_string)
                    begin
                        count    = upd_pkg::CNT_W'(2);
                        bytes[0] = upd_pkg::CH_PERCENT;
                        bytes[1] = in_byte;
                    end
                    else
                    begin
                        phase_next = upd_pkg::PH_DIGIT;
                        first_next = in_byte;
                    end
                end
                else
                begin
                    count    = upd_pkg::CNT_W'(1) + upd_pkg::CNT_W'(plain_n);
                    bytes[0] = upd_pkg::CH_PERCENT;
                    bytes[1] = plain_byte;
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (hex_in)
                begin
                    count      = upd_pkg::CNT_W'(1);
                    bytes[0]   = {upd_pkg::hex_val(first_reg), upd_pkg::hex_val(in_byte)};
                    phase_next = upd_pkg::PH_IDLE;
                end
                else
                begin
                    count    = upd_pkg::CNT_W'(2) + upd_pkg::CNT_W'(plain_n);
                    bytes[0] = upd_pkg::CH_PERCENT;
                    bytes[1] = first_reg;
                    bytes[2] = plain_byte;
                end
            end
            default:
            begin
                count    = upd_pkg::CNT_W'(plain_n);
                bytes[0] = plain_byte;
            end
        endcase
        if (end_of_string)
        begin
            phase_next = upd_pkg::PH_IDLE;
            first_next = '0;
        end
    end

    assign cmd_push       = accept && (count != '0);
    assign cmd.count      = count;
    assign cmd.bytes      = bytes;
    assign cmd.string_end = end_of_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upd_pkg::PH_IDLE;
            first_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_queue.sv -----
`default_nettype none

module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  upd_pkg::upd_cmd_t      push_cmd,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output upd_pkg::upd_cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    upd_pkg::upd_cmd_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (level_reg == LVL_W'(DEPTH));
    assign head_valid = (level_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/upd_back.sv -----
`default_nettype none

module upd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  upd_pkg::upd_cmd_t      head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_last,
    output logic                   string_last
);

    logic [upd_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      run_last_reg;
    logic                      string_last_reg;

    logic load;
    logic at_last;

    // A queued byte loads whenever the output register is empty or being drained.
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == head.count - upd_pkg::CNT_W'(1));
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = at_last ? '0 : idx_reg + upd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= head.bytes[idx_reg];
            run_last_reg    <= at_last;
            string_last_reg <= at_last && head.string_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_last = string_last_reg;

endmodule

`default_nettype wire

// ----- rtl/url_percent_decoder.sv -----
// Streaming form-URL percent decoder.
// Input channel: in_valid/in_ready with in_byte and end_of_string, one string
// character per item. Output channel: out_valid/out_ready with out_byte,
// run_last (last byte caused by an input item) and string_last (final byte of
// the string). An item may cause zero to three output bytes.
// The front decodes each item in the cycle it is accepted and pushes up to
// three bytes as one entry into a QUEUE_DEPTH-entry queue; the back sends one
// byte per cycle from the queue head through an output register while the
// receiver is ready; a byte sits in its queue entry, then in that register.
// Throughput: one input item per cycle while each item yields at most one
// byte and the receiver is ready; an item yielding several bytes holds its
// queue entry until all are sent; the queue absorbs these bursts until full.
// in_ready drops only when the queue is full, so a stalled receiver holds the
// output register and then backs up the queue before the input stalls.
// Reset clears the escape state, the queue and the output valid flag; no
// clearing pass is needed and the block accepts items right after reset.
`default_nettype none

`include "assert_macros.svh"

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_string,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             string_last
);

    upd_pkg::upd_cmd_t push_cmd;
    upd_pkg::upd_cmd_t head;
    logic              cmd_push;
    logic              queue_full;
    logic              head_valid;
    logic              pop;
    logic              escape_pending;

    upd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_byte        (in_byte),
        .end_of_string  (end_of_string),
        .queue_full     (queue_full),
        .in_ready       (in_ready),
        .cmd_push       (cmd_push),
        .cmd            (push_cmd),
        .escape_pending (escape_pending)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

    `UPD_ASSERT_IMPL(a_push_not_full, clk, rst_n, cmd_push, !queue_full)
    `UPD_ASSERT_IMPL(a_end_has_output, clk, rst_n, in_valid && in_ready && end_of_string, cmd_push)
    `UPD_ASSERT_NEXT(a_end_clears_escape, clk, rst_n, in_valid && in_ready && end_of_string, !escape_pending)
    `UPD_ASSERT_IMPL(a_string_last_is_run_last, clk, rst_n, out_valid && string_last, run_last)

endmodule

`default_nettype wire

// ----- tb/tb_url_percent_decoder.sv -----
`default_nettype none

module tb_url_percent_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // One row of directed stimulus. When "typed" is set, the row carries its
    // expected output bytes (e0 first); otherwise the predictor supplies them.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } dec_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_string = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    dec_byte_t           decoded_q[$];
    upd_pkg::upd_phase_t esc_phase = upd_pkg::PH_IDLE;
    logic [7:0]          held_digit = 8'h00;
    bit                  idle_en = 1'b1;
    bit                  failed = 1'b0;

    stim_row_t dir_rows [0:27] = '{
        '{8'h41,      1'b0, 1'b1, 2'd1, 8'h41,      8'h00, 8'h00},
        '{8'h01,      1'b0, 1'b1, 2'd1, 8'h01,      8'h00, 8'h00},
        '{8'hFF,      1'b0, 1'b1, 2'd1, 8'hFF,      8'h00, 8'h00},
        '{upd_pkg::CH_PLUS, 1'b0, 1'b1, 2'd1, upd_pkg::CH_SPACE, 8'h00, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h34,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00, 8'h00},
        '{8'h31,      1'b0, 1'b1, 2'd1, 8'h41,      8'h00, 8'h00},
        // An escape of zero still yields a byte.
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h30,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00, 8'h00},
        '{8'h30,      1'b0, 1'b1, 2'd1, 8'h00,      8'h00, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h66,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00, 8'h00},
        '{8'h46,      1'b0, 1'b1, 2'd1, 8'hFF,      8'h00, 8'h00},
        // Non-hex first digit: the percent goes out literally.
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h47,      1'b0, 1'b1, 2'd2, upd_pkg::CH_PERCENT, 8'h47, 8'h00},
        // Non-hex second digit: percent, held digit, then the plus decoded.
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h61,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00, 8'h00},
        '{upd_pkg::CH_PLUS, 1'b0, 1'b1, 2'd3, upd_pkg::CH_PERCENT, 8'h61,
          upd_pkg::CH_SPACE},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h62,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b1, 2'd2, upd_pkg::CH_PERCENT, 8'h62, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b1, 1'b1, 2'd2, upd_pkg::CH_PERCENT,
          upd_pkg::CH_PERCENT, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b1, 1'b1, 2'd1, upd_pkg::CH_PERCENT, 8'h00, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h37,      1'b1, 1'b1, 2'd2, upd_pkg::CH_PERCENT, 8'h37, 8'h00},
        '{upd_pkg::CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h33,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00, 8'h00},
        '{8'h40,      1'b1, 1'b1, 2'd3, upd_pkg::CH_PERCENT, 8'h33, 8'h40}
    };

    url_percent_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .string_last   (string_last)
    );

    always #5 clk = ~clk;

    // Bit 4 flags a hex digit; the low nibble is its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return {1'b1, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'h00;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < upd_pkg::HEX_ALPHA)
        begin
            return 8'h30 + {4'h0, v};
        end
        return (upper ? 8'h41 : 8'h61) + {4'h0, v - upd_pkg::HEX_ALPHA};
    endfunction

    // Advances the escape state by one character and returns the bytes it emits.
    function automatic int decode_char(input logic [7:0] c, input logic eos,
                                       output logic [2:0][7:0] res);
        int                  n;
        logic [4:0]          cur;
        logic [4:0]          prev;
        logic                as_plain;
        upd_pkg::upd_phase_t next_ph;
        n = 0;
        res = '0;
        cur = hex_digit(c);
        prev = hex_digit(held_digit);
        as_plain = 1'b0;
        next_ph = upd_pkg::PH_IDLE;
        case (esc_phase)
            upd_pkg::PH_PCT:
            begin
                if (cur[4] && eos)
                begin
                    res[0] = upd_pkg::CH_PERCENT;
                    res[1] = c;
                    n = 2;
                end
                else if (cur[4])
                begin
                    held_digit = c;
                    next_ph = upd_pkg::PH_DIGIT;
                end
                else
                begin
                    res[0] = upd_pkg::CH_PERCENT;
                    n = 1;
                    as_plain = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (cur[4])
                begin
                    res[0] = {prev[3:0], cur[3:0]};
                    n = 1;
                end
                else
                begin
                    res[0] = upd_pkg::CH_PERCENT;
                    res[1] = held_digit;
                    n = 2;
                    as_plain = 1'b1;
                end
            end
            default:
            begin
                as_plain = 1'b1;
            end
        endcase
        if (as_plain)
        begin
            if (c == upd_pkg::CH_PERCENT && !eos)
            begin
                next_ph = upd_pkg::PH_PCT;
            end
            else
            begin
                res[n] = (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;
                n++;
            end
        end
        esc_phase = next_ph;
        if (eos)
        begin
            esc_phase = upd_pkg::PH_IDLE;
            held_digit = 8'h00;
        end
        return n;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input stim_row_t r);
        logic [2:0][7:0] res;
        int              n;
        while (idle_en && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= r.ch;
        end_of_string <= r.eos;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n = decode_char(r.ch, r.eos, res);
        if (r.typed)
        begin
            n = int'(r.n);
            res = {r.e2, r.e1, r.e0};
        end
        for (int k = 0; k < n; k++)
        begin
            decoded_q.push_back('{res[k], k == n - 1, r.eos && (k == n - 1)});
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready <= idle_en ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end

    always @(posedge clk)
    begin
        dec_byte_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected byte %h, nothing pending", $realtime, out_byte);
                failed = 1'b1;
            end
            else
            begin
                e = decoded_q.pop_front();
                if (out_byte !== e.data)
                begin
                    $display("%0t: out_byte expected %h actual %h",
                             $realtime, e.data, out_byte);
                    failed = 1'b1;
                end
                if (run_last !== e.run_end)
                begin
                    $display("%0t: run_last expected %b actual %b",
                             $realtime, e.run_end, run_last);
                    failed = 1'b1;
                end
                if (string_last !== e.str_end)
                begin
                    $display("%0t: string_last expected %b actual %b",
                             $realtime, e.str_end, string_last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] str_q[$];
        int         chars_sent;
        int         len;
        int         pick;
        chars_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            send_char(dir_rows[i]);
        end

        // Let the decoder drain completely before the random strings start.
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);

        while (chars_sent < 400)
        begin
            str_q.delete();
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    str_q.push_back(upd_pkg::CH_PERCENT);
                    str_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
                    str_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
                end
                else if (pick < 45)
                begin
                    str_q.push_back(upd_pkg::CH_PLUS);
                end
                else if (pick < 52)
                begin
                    // A lone percent; whatever follows decides what it becomes.
                    str_q.push_back(upd_pkg::CH_PERCENT);
                end
                else if (pick < 60)
                begin
                    str_q.push_back(upd_pkg::CH_PERCENT);
                    str_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
                    str_q.push_back(8'($urandom_range(1, 255)));
                end
                else
                begin
                    str_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            foreach (str_q[k])
            begin
                idle_en = !(chars_sent >= 150 && chars_sent < 260);
                send_char('{str_q[k], k == str_q.size() - 1, 1'b0, 2'd0,
                            8'h00, 8'h00, 8'h00});
                chars_sent++;
            end
        end

        in_valid <= 1'b0;
        idle_en = 1'b1;
        while (decoded_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (upd_pkg::QUEUE_DEPTH * upd_pkg::MAX_RESULTS + 4) @(negedge clk);
        if (failed)
        begin
            $display("FAIL");
        end
        else
        begin
            $display("PASS");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d bytes still pending", $realtime, decoded_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
